// ===== rtl/rrst_pkg.sv =====
// Package: shared constants and control structs for the round-robin scheduler.
package rrst_pkg;

  localparam int unsigned TimeW  = 17;
  localparam int unsigned ArrW   = 16;
  localparam int unsigned BurstW = 12;
  localparam int unsigned TotW   = 21;
  localparam int unsigned IdW    = 5;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // store the accepted input item
    logic init;       // start of scheduling: clear queue, push first ranked
    logic rank_step;  // one insertion step of the ranking
    logic pop;        // pop head and run one time slice
    logic scan_step;  // one rank position of the arrival scan
    logic finish_cp;  // requeue preempted, refill if queue empty
    logic out_init;   // reset output index, load totals from first result
    logic out_next;   // advance output index
    logic clear;      // clear the set after output
  } rrst_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic sched_now;  // accepted item ends the set
    logic rank_done;  // ranking finished
    logic all_done;   // every process completed
    logic queue_empty;
    logic scan_done;  // last rank position scanned
    logic out_last;   // current output is the last one
  } rrst_sts_t;

endpackage

// ===== rtl/round_robin_schedule_timing.sv =====
// Top level: round-robin CPU schedule timing over a loaded process set.
// Processes load one per cycle. After the item marked last (or the one that
// fills the MaxProcs store) input stalls while the scheduler ranks the set by
// arrival (up to about n*n/2 insertion steps), then runs each time slice as a
// pop and slice, an arrival scan over every rank position, and a requeue.
// Results leave one per unstalled cycle in id order, with running totals.
module round_robin_schedule_timing #(
  parameter int unsigned MaxProcs = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] arrival_time_i,
  input  logic [11:0] burst_time_i,
  input  logic        last_process_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [4:0]  process_id_o,
  output logic [16:0] run_start_o,
  output logic [16:0] run_end_o,
  output logic [16:0] tat_o,
  output logic [16:0] queue_wait_o,
  output logic [20:0] total_turnaround_o,
  output logic [20:0] total_waiting_o,
  output logic        last_result_o
);

  rrst_pkg::rrst_cmd_t cmd;
  rrst_pkg::rrst_sts_t sts;
  logic [11:0] time_quantum_q;

  // Quantum register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) time_quantum_q <= 12'd4;
    else if (cfg_we_i) time_quantum_q <= cfg_wdata_i;
  end

  rrst_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  rrst_dp #(.MaxProcs(MaxProcs)) u_dp (
    .clk_i, .rst_ni, .time_quantum_i(time_quantum_q),
    .arrival_time_i, .burst_time_i, .last_process_i,
    .cmd_i(cmd), .sts_o(sts),
    .process_id_o, .run_start_o, .run_end_o, .tat_o,
    .queue_wait_o, .total_turnaround_o, .total_waiting_o, .last_result_o
  );

  // No input transfer while results are offered
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input taken during output");
  // First result of a set carries id 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> process_id_o == 5'd1)
    else $error("output does not start at id 1");
  // Last result transfer ends the output phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_result_o) |=> !out_valid_o)
    else $error("output continued past last result");

endmodule

// ===== rtl/rrst_ctrl.sv =====
// Controller: sequencing of load, ranking, time slices and result output.
module rrst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rrst_pkg::rrst_sts_t sts_i,
  output rrst_pkg::rrst_cmd_t cmd_o
);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StRank = 3'd1;
  localparam logic [2:0] StInit = 3'd2;
  localparam logic [2:0] StPop  = 3'd3;
  localparam logic [2:0] StScan = 3'd4;
  localparam logic [2:0] StFin  = 3'd5;
  localparam logic [2:0] StOut  = 3'd6;

  logic [2:0] state_q, state_d;
  logic in_xfer, out_xfer;

  assign in_stall_o  = (state_q != StLoad);
  assign out_valid_o = (state_q == StOut);
  assign in_xfer     = in_valid_i && (state_q == StLoad);
  assign out_xfer    = out_valid_o && !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StLoad: begin
        if (in_xfer) begin
          cmd_o.load = 1'b1;
          if (sts_i.sched_now) state_d = StRank;
        end
      end
      StRank: begin
        if (sts_i.rank_done) state_d = StInit;
        else cmd_o.rank_step = 1'b1;
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d = StPop;
      end
      StPop: begin
        if (sts_i.all_done || sts_i.queue_empty) begin
          cmd_o.out_init = 1'b1;
          state_d = StOut;
        end else begin
          cmd_o.pop = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = StFin;
      end
      StFin: begin
        cmd_o.finish_cp = 1'b1;
        state_d = StPop;
      end
      StOut: begin
        if (out_xfer) begin
          cmd_o.out_next = 1'b1;
          if (sts_i.out_last) begin
            cmd_o.clear = 1'b1;
            state_d = StLoad;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StLoad;
    else state_q <= state_d;
  end

endmodule

// ===== rtl/rrst_dp.sv =====
// Datapath: process stores, ranking, ready queue, time keeping and results.
module rrst_dp #(
  parameter int unsigned MaxProcs = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [11:0]                  time_quantum_i,
  input  logic [rrst_pkg::ArrW-1:0]    arrival_time_i,
  input  logic [rrst_pkg::BurstW-1:0]  burst_time_i,
  input  logic                         last_process_i,
  input  rrst_pkg::rrst_cmd_t          cmd_i,
  output rrst_pkg::rrst_sts_t          sts_o,
  output logic [rrst_pkg::IdW-1:0]     process_id_o,
  output logic [rrst_pkg::TimeW-1:0]   run_start_o,
  output logic [rrst_pkg::TimeW-1:0]   run_end_o,
  output logic [rrst_pkg::TimeW-1:0]   tat_o,
  output logic [rrst_pkg::TimeW-1:0]   queue_wait_o,
  output logic [rrst_pkg::TotW-1:0]    total_turnaround_o,
  output logic [rrst_pkg::TotW-1:0]    total_waiting_o,
  output logic                         last_result_o
);

  localparam int unsigned IW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
  localparam int unsigned CW = $clog2(MaxProcs + 1);
  localparam int unsigned TW = rrst_pkg::TimeW;

  logic [rrst_pkg::ArrW-1:0]   arr_q [MaxProcs];
  logic [rrst_pkg::BurstW-1:0] bur_q [MaxProcs];
  logic [rrst_pkg::BurstW-1:0] rem_q [MaxProcs];
  logic [TW-1:0]               st_q  [MaxProcs];
  logic [TW-1:0]               cmp_q [MaxProcs];
  logic [IW-1:0]               rank_q [MaxProcs];
  // ready queue wraps at the index width
  logic [IW-1:0]               rq_q  [2**IW];
  logic [MaxProcs-1:0]         queued_q, started_q, done_q;
  logic [CW-1:0]               cnt_q, compl_q, rq_len_q;
  logic [IW-1:0]               rq_head_q, rq_tail_q;
  logic [TW-1:0]               time_q;
  logic [IW-1:0]               cp_q;
  // ranking: outer index i, inner position k
  logic [CW-1:0]               ri_q, rk_q;
  logic [CW-1:0]               sk_q;
  logic [IW-1:0]               oi_q;
  logic [rrst_pkg::TotW-1:0]   tot_tat_q, tot_wt_q;

  logic [IW-1:0] slot;
  logic [CW-1:0] cnt_inc;
  assign slot    = (cnt_q >= CW'(MaxProcs)) ? IW'(MaxProcs - 1) : cnt_q[IW-1:0];
  assign cnt_inc = CW'(slot) + CW'(1);

  logic [11:0] q_eff;
  assign q_eff = (time_quantum_i == 12'd0) ? 12'd1 : time_quantum_i;

  // Ranking comparison for current insertion step
  logic [IW-1:0] ri_idx, rk_idx, rkm1_idx, rk_id;
  logic          shift_ok;
  assign ri_idx   = ri_q[IW-1:0];
  assign rk_idx   = rk_q[IW-1:0];
  assign rkm1_idx = IW'(rk_q - CW'(1));
  assign rk_id    = rank_q[rkm1_idx];
  assign shift_ok = (rk_q != '0) && (arr_q[rk_id] > arr_q[ri_idx]);

  // Scan candidate
  logic [IW-1:0] s_id;
  logic          s_push;
  assign s_id   = rank_q[sk_q[IW-1:0]];
  assign s_push = !done_q[s_id] && !queued_q[s_id] && ({1'b0, arr_q[s_id]} <= time_q);

  // Refill search: first incomplete in rank order (over the ranked entries)
  logic          ref_found;
  logic [IW-1:0] ref_id;
  always_comb begin
    ref_found = 1'b0;
    ref_id    = '0;
    for (int k = MaxProcs - 1; k >= 0; k--) begin
      if ((CW'(k) < cnt_q) && !done_q[rank_q[IW'(k)]]) begin
        ref_found = 1'b1;
        ref_id    = rank_q[IW'(k)];
      end
    end
  end

  // Slice arithmetic for the popped process
  logic [IW-1:0] pop_id;
  logic [TW-1:0] t_start;
  logic          fin;
  assign pop_id  = rq_q[rq_head_q];
  assign t_start = (!started_q[pop_id] && ({1'b0, arr_q[pop_id]} > time_q))
                   ? {1'b0, arr_q[pop_id]} : time_q;
  assign fin     = (rem_q[pop_id] <= q_eff);

  logic          fin_requeue;
  assign fin_requeue = !done_q[cp_q];

  // Result values for the current and next output index
  logic [TW-1:0] tat_cur, wt_cur, tat_nx, wt_nx;
  logic [IW-1:0] oi_nx;
  assign oi_nx   = oi_q + IW'(1);
  assign tat_cur = cmp_q[oi_q] - {1'b0, arr_q[oi_q]};
  assign wt_cur  = tat_cur - TW'(bur_q[oi_q]);
  assign tat_nx  = cmp_q[oi_nx] - {1'b0, arr_q[oi_nx]};
  assign wt_nx   = tat_nx - TW'(bur_q[oi_nx]);

  function automatic logic [rrst_pkg::TotW-1:0] TotWv(input logic [TW-1:0] v);
    return {{(rrst_pkg::TotW - TW){1'b0}}, v};
  endfunction

  function automatic logic [TW-1:0] turnaround_first();
    return cmp_q[0] - {1'b0, arr_q[0]};
  endfunction

  function automatic logic [TW-1:0] waiting_first();
    return cmp_q[0] - {1'b0, arr_q[0]} - TW'(bur_q[0]);
  endfunction

  // Status
  assign sts_o.sched_now   = last_process_i || (cnt_inc >= CW'(MaxProcs));
  assign sts_o.rank_done   = (ri_q >= cnt_q);
  assign sts_o.all_done    = (compl_q >= cnt_q);
  assign sts_o.queue_empty = (rq_len_q == '0);
  assign sts_o.scan_done   = (sk_q + CW'(1) >= cnt_q);
  assign sts_o.out_last    = (CW'(oi_q) + CW'(1) >= cnt_q);

  // Stores and scheduling state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      arr_q[slot] <= arrival_time_i;
      bur_q[slot] <= burst_time_i;
      rem_q[slot] <= burst_time_i;
    end
    if (cmd_i.rank_step) begin
      if (shift_ok) rank_q[rk_idx] <= rk_id;
      else rank_q[rk_idx] <= ri_idx;
    end
    if (cmd_i.init) rq_q[0] <= rank_q[0];
    if (cmd_i.pop) begin
      cp_q <= pop_id;
      if (!started_q[pop_id]) st_q[pop_id] <= t_start;
      if (fin) begin
        rem_q[pop_id] <= '0;
        cmp_q[pop_id] <= t_start + TW'(rem_q[pop_id]);
      end else begin
        rem_q[pop_id] <= rem_q[pop_id] - q_eff;
      end
    end
    if (cmd_i.scan_step && s_push) rq_q[rq_tail_q] <= s_id;
    if (cmd_i.finish_cp) begin
      if (fin_requeue) rq_q[rq_tail_q] <= cp_q;
      else if (rq_len_q == '0 && ref_found) rq_q[rq_tail_q] <= ref_id;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; compl_q <= '0; rq_len_q <= '0;
      rq_head_q <= '0; rq_tail_q <= '0; time_q <= '0;
      queued_q <= '0; started_q <= '0; done_q <= '0;
      ri_q <= '0; rk_q <= '0; sk_q <= '0; oi_q <= '0;
      tot_tat_q <= '0; tot_wt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= cnt_inc;
        ri_q  <= '0;
        rk_q  <= '0;
      end
      if (cmd_i.rank_step) begin
        if (shift_ok) rk_q <= rk_q - CW'(1);
        else begin
          ri_q <= ri_q + CW'(1);
          rk_q <= ri_q + CW'(1);
        end
      end
      if (cmd_i.init) begin
        queued_q  <= {{(MaxProcs - 1){1'b0}}, 1'b1} << rank_q[0];
        started_q <= '0; done_q <= '0; compl_q <= '0;
        rq_head_q <= '0;
        rq_tail_q <= IW'(1);
        rq_len_q  <= CW'(1);
        time_q    <= '0;
      end
      if (cmd_i.pop) begin
        rq_head_q <= rq_head_q + IW'(1);
        rq_len_q  <= rq_len_q - CW'(1);
        started_q[pop_id] <= 1'b1;
        sk_q <= '0;
        if (fin) begin
          time_q  <= t_start + TW'(rem_q[pop_id]);
          done_q[pop_id] <= 1'b1;
          compl_q <= compl_q + CW'(1);
        end else begin
          time_q <= t_start + TW'(q_eff);
        end
      end
      if (cmd_i.scan_step) begin
        sk_q <= sk_q + CW'(1);
        if (s_push) begin
          rq_tail_q <= rq_tail_q + IW'(1);
          rq_len_q  <= rq_len_q + CW'(1);
          queued_q[s_id] <= 1'b1;
        end
      end
      if (cmd_i.finish_cp) begin
        if (fin_requeue) begin
          rq_tail_q <= rq_tail_q + IW'(1);
          rq_len_q  <= rq_len_q + CW'(1);
        end else if (rq_len_q == '0 && ref_found) begin
          rq_tail_q <= rq_tail_q + IW'(1);
          rq_len_q  <= rq_len_q + CW'(1);
          queued_q[ref_id] <= 1'b1;
        end
      end
      if (cmd_i.out_init) begin
        oi_q <= '0;
        tot_tat_q <= TotWv(turnaround_first());
        tot_wt_q  <= TotWv(waiting_first());
      end
      if (cmd_i.out_next) begin
        oi_q <= oi_q + IW'(1);
        tot_tat_q <= tot_tat_q + TotWv(tat_nx);
        tot_wt_q  <= tot_wt_q + TotWv(wt_nx);
      end
      if (cmd_i.clear) begin
        cnt_q <= '0; rq_len_q <= '0; rq_head_q <= '0; rq_tail_q <= '0;
        time_q <= '0; queued_q <= '0;
      end
    end
  end

  // Outputs
  assign process_id_o       = rrst_pkg::IdW'(CW'(oi_q) + CW'(1));
  assign run_start_o        = st_q[oi_q];
  assign run_end_o          = cmp_q[oi_q];
  assign tat_o              = tat_cur;
  assign queue_wait_o       = wt_cur;
  assign total_turnaround_o = tot_tat_q;
  assign total_waiting_o    = tot_wt_q;
  assign last_result_o      = sts_o.out_last;

endmodule

// ===== tb/round_robin_schedule_timing_tb.sv =====
// Testbench: round-robin schedule timing block, directed table plus random process sets.
`timescale 1ns / 1ps

module round_robin_schedule_timing_tb;

  localparam int unsigned SetMax    = 16;
  localparam int unsigned StallLong = 400;
  localparam int unsigned IdleLimit = 300000;

  typedef struct packed {
    logic [rrst_pkg::IdW-1:0]   id;
    logic [rrst_pkg::TimeW-1:0] start;
    logic [rrst_pkg::TimeW-1:0] finish;
    logic [rrst_pkg::TimeW-1:0] turnaround;
    logic [rrst_pkg::TimeW-1:0] waiting;
    logic [rrst_pkg::TotW-1:0]  sum_turnaround;
    logic [rrst_pkg::TotW-1:0]  sum_waiting;
    logic                       last;
  } proc_timing_t;

  typedef struct packed {
    logic [rrst_pkg::ArrW-1:0]   arrival;
    logic [rrst_pkg::BurstW-1:0] burst;
    logic                        last;
    logic                        typed;   // expectation given in the table
    proc_timing_t                timing;
  } proc_load_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [11:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] arrival_time_i = '0;
  logic [11:0] burst_time_i = '0;
  logic last_process_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [4:0] process_id_o;
  logic [16:0] run_start_o, run_end_o, tat_o, queue_wait_o;
  logic [20:0] total_turnaround_o, total_waiting_o;
  logic last_result_o;

  round_robin_schedule_timing #(.MaxProcs(SetMax)) DUT (.*);

  always #2 clk_i = ~clk_i;

  // scoreboard state
  proc_load_t   offered_q[$];
  proc_timing_t timing_q[$];
  logic [11:0]  quantum = 12'd4;
  logic [rrst_pkg::ArrW-1:0]   set_arrival[SetMax];
  logic [rrst_pkg::BurstW-1:0] set_burst[SetMax];
  int unsigned set_count = 0;
  int unsigned errors = 0, loads_done = 0, results_done = 0, sets_done = 0;
  int unsigned idle_cycles = 0;
  bit hold_request = 1'b0;
  bit no_idle = 1'b0;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // round-robin schedule of the collected set, results in id order
  task automatic schedule_set();
    int unsigned rank[SetMax], left[SetMax], began[SetMax], ended[SetMax];
    bit started[SetMax], complete[SetMax], queued[SetMax];
    int ready[$];
    int unsigned now, slice, tat, wt, sum_tat, sum_wt, completed;
    int k, cp, id;
    proc_timing_t r;
    slice = (quantum == 0) ? 1 : quantum;
    for (int i = 0; i < set_count; i++) begin
      k = i;
      while (k > 0 && set_arrival[rank[k-1]] > set_arrival[i]) begin
        rank[k] = rank[k-1];
        k--;
      end
      rank[k] = i;
      left[i] = set_burst[i];
      started[i] = 0; complete[i] = 0; queued[i] = 0;
    end
    now = 0; completed = 0;
    ready.push_back(rank[0]);
    queued[rank[0]] = 1;
    while (completed < set_count && ready.size() > 0) begin
      cp = ready.pop_front();
      if (!started[cp]) begin
        if (set_arrival[cp] > now) now = set_arrival[cp];
        began[cp] = now;
        started[cp] = 1;
      end
      if (left[cp] > slice) begin
        left[cp] -= slice;
        now += slice;
      end else begin
        now += left[cp];
        left[cp] = 0;
        complete[cp] = 1;
        completed++;
        ended[cp] = now;
      end
      // arrivals join before the preempted process
      for (int j = 0; j < set_count; j++) begin
        id = rank[j];
        if (!complete[id] && !queued[id] && set_arrival[id] <= now) begin
          ready.push_back(id);
          queued[id] = 1;
        end
      end
      if (!complete[cp]) ready.push_back(cp);
      if (ready.size() == 0) begin
        for (int j = 0; j < set_count; j++) begin
          id = rank[j];
          if (!complete[id]) begin
            ready.push_back(id);
            queued[id] = 1;
            break;
          end
        end
      end
    end
    sum_tat = 0; sum_wt = 0;
    for (int i = 0; i < set_count; i++) begin
      tat = ended[i] - set_arrival[i];
      wt = tat - set_burst[i];
      sum_tat += tat;
      sum_wt += wt;
      r.id = rrst_pkg::IdW'(i + 1);
      r.start = rrst_pkg::TimeW'(began[i]);
      r.finish = rrst_pkg::TimeW'(ended[i]);
      r.turnaround = rrst_pkg::TimeW'(tat);
      r.waiting = rrst_pkg::TimeW'(wt);
      r.sum_turnaround = rrst_pkg::TotW'(sum_tat);
      r.sum_waiting = rrst_pkg::TotW'(sum_wt);
      r.last = (i + 1 == set_count);
      timing_q.push_back(r);
    end
  endtask

  // input transfers feed the predictor
  always @(posedge clk_i) begin
    proc_load_t item;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      item = offered_q.pop_front();
      set_arrival[set_count] = arrival_time_i;
      set_burst[set_count] = burst_time_i;
      set_count++;
      loads_done++;
      if (last_process_i || set_count == SetMax) begin
        if (item.typed) timing_q.push_back(item.timing);
        else schedule_set();
        set_count = 0;
        sets_done++;
      end
    end
  end

  // output transfers against the oldest expectation
  always @(posedge clk_i) begin
    proc_timing_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_done++;
      if (timing_q.size() == 0) begin
        report_mismatch("unexpected result, process_id", process_id_o, 0);
      end else begin
        want = timing_q.pop_front();
        if (process_id_o !== want.id) report_mismatch("process_id", process_id_o, want.id);
        if (run_start_o !== want.start)
          report_mismatch("run_start", run_start_o, want.start);
        if (run_end_o !== want.finish)
          report_mismatch("run_end", run_end_o, want.finish);
        if (tat_o !== want.turnaround)
          report_mismatch("tat", tat_o, want.turnaround);
        if (queue_wait_o !== want.waiting)
          report_mismatch("queue_wait", queue_wait_o, want.waiting);
        if (total_turnaround_o !== want.sum_turnaround)
          report_mismatch("total_turnaround", total_turnaround_o, want.sum_turnaround);
        if (total_waiting_o !== want.sum_waiting)
          report_mismatch("total_waiting", total_waiting_o, want.sum_waiting);
        if (last_result_o !== want.last)
          report_mismatch("last_result", last_result_o, want.last);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("round_robin_schedule_timing test failed");
      $finish;
    end
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int unsigned wait_n;
    @(posedge rst_ni);
    forever begin
      wait_n = no_idle ? 0 : $urandom_range(0, 16);
      if (hold_request) begin
        wait_n = StallLong;
        hold_request = 1'b0;
      end
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // offer one process, random gap in front
  task automatic send_process(proc_load_t item);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    offered_q.push_back(item);
    in_valid_i <= 1'b1;
    arrival_time_i <= item.arrival;
    burst_time_i <= item.burst;
    last_process_i <= item.last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // sender pauses until every result is back, then the block settles
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (timing_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_quantum(logic [11:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    quantum = value;
  endtask

  function automatic proc_load_t load_row(int a, int b, bit l);
    proc_load_t p;
    p = '0;
    p.arrival = rrst_pkg::ArrW'(a);
    p.burst = rrst_pkg::BurstW'(b);
    p.last = l;
    return p;
  endfunction

  function automatic proc_load_t typed_row(int a, int b, int st, int cm);
    proc_load_t p;
    p = load_row(a, b, 1'b1);
    p.typed = 1'b1;
    p.timing.id = rrst_pkg::IdW'(1);
    p.timing.start = rrst_pkg::TimeW'(st);
    p.timing.finish = rrst_pkg::TimeW'(cm);
    p.timing.turnaround = rrst_pkg::TimeW'(cm - a);
    p.timing.waiting = rrst_pkg::TimeW'(cm - a - b);
    p.timing.sum_turnaround = rrst_pkg::TotW'(cm - a);
    p.timing.sum_waiting = rrst_pkg::TotW'(cm - a - b);
    p.timing.last = 1'b1;
    return p;
  endfunction

  initial begin
    proc_load_t table_rows[$];
    proc_load_t p;
    int unsigned phase_quanta[8] = '{0, 1, 4095, 2, 37, 300, 4, 1000};
    int unsigned sent, set_size, base, spread, cap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero burst, ties, idle CPU, a store-filling set
    table_rows.push_back(typed_row(0, 1, 0, 1));
    table_rows.push_back(typed_row(65535, 4095, 65535, 69630));
    table_rows.push_back(typed_row(5, 0, 5, 5));
    table_rows.push_back(load_row(10, 7, 0));
    table_rows.push_back(load_row(0, 3, 0));
    table_rows.push_back(load_row(10, 2, 0));
    table_rows.push_back(load_row(3, 9, 0));
    table_rows.push_back(load_row(0, 5, 1));
    table_rows.push_back(load_row(0, 2, 0));
    table_rows.push_back(load_row(100, 3, 1));
    for (int i = 0; i < SetMax; i++)
      table_rows.push_back(load_row((i * 7) % 23, (i == 3) ? 4095 : (i == 9 ? 0 : i + 1), 0));
    foreach (table_rows[i]) send_process(table_rows[i]);
    drain();

    // random phases, one quantum each
    for (int ph = 0; ph < 8; ph++) begin
      write_quantum((ph >= 6) ? 12'($urandom_range(16, 4095)) : 12'(phase_quanta[ph]));
      if (ph == 3) hold_request = 1'b1;
      no_idle = (ph == 4);
      cap = (quantum <= 2) ? 15 : ((quantum * 6 > 4095) ? 4095 : quantum * 6);
      sent = 0;
      while (sent < 29) begin
        set_size = ($urandom_range(0, 3) == 0) ? SetMax : $urandom_range(1, SetMax);
        base = $urandom_range(0, 65535 - 4000);
        spread = $urandom_range(0, 1) ? 50 : 3000;
        for (int i = 0; i < set_size; i++) begin
          p = load_row(base + $urandom_range(0, spread), $urandom_range(0, cap),
                       i == set_size - 1);
          if ($urandom_range(0, 9) == 0) p.arrival = rrst_pkg::ArrW'($urandom);
          if (i == SetMax - 1) p.last = $urandom_range(0, 1);
          if (ph == 0 && $urandom_range(0, 9) == 0) p.last = 1'b0;
          send_process(p);
          sent++;
          if (ph == 0 && !p.last && set_count == 0 && i < set_size - 1) break;
        end
      end
      // an open set closes before the phase ends
      if (set_count != 0 || offered_q.size() > 0)
        send_process(load_row($urandom_range(0, 65535), $urandom_range(0, cap), 1'b1));
      drain();
    end
    no_idle = 1'b0;

    while (timing_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d process loads in %0d sets, %0d timing results checked,",
             loads_done, sets_done, results_done);
    $display("quantum from zero to 4095, with stalls, gaps and a long output hold-off.");
    if (errors == 0 && timing_q.size() == 0) begin
      $display("round_robin_schedule_timing test passed");
    end else begin
      $display("round_robin_schedule_timing test failed");
    end
    $finish;
  end

endmodule
